// ===== design/tlhb_pkg.sv =====
package tlhb_pkg;

    // defaults handed to the top level parameters
    localparam int DEF_MAX_LINE_CHARS = 128;
    localparam int DEF_KEPT_LINES     = 31;
    localparam int DEF_STORE_DEPTH    = 4096;

    // line length queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int QUEUE_AW    = 5;

    // field widths fixed by the item layout
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 12;
    localparam int TEXT_LEN_W  = 13;
    localparam int LINE_CNT_W  = 5;
    localparam int LINE_CHAR_W = 8;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes on the configuration port
    localparam logic REG_LINE_LIMIT     = 1'b0;
    localparam logic REG_CHARS_PER_LINE = 1'b1;

    // reset values of the configuration registers
    localparam logic [4:0] LINE_LIMIT_RST     = 5'd31;
    localparam logic [7:0] CHARS_PER_LINE_RST = 8'd128;

    // special bytes
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;

    typedef struct packed {
        logic               op;
        logic [CHAR_W-1:0]  data_byte;
        logic [INDEX_W-1:0] read_index;
        logic               last_of_call;
    } t_in_item;

    typedef struct packed {
        logic                  byte_changed;
        logic                  call_changed;
        logic [CHAR_W-1:0]     read_char;
        logic [TEXT_LEN_W-1:0] text_length;
        logic [LINE_CNT_W-1:0] line_count;
    } t_out_item;

    typedef struct packed {
        logic [4:0] line_limit;
        logic [7:0] chars_per_line;
    } t_cfg;

endpackage

// ===== design/terminal_line_history_buffer.sv =====
// Terminal line history buffer: keeps the text of a serial terminal as edited
// lines in a circular character store and answers reads of single stored
// characters. A put transaction edits one received byte into the text (ESC
// opens a colour sequence closed by 'm', CR drops the open line, BS removes its
// last character, LF closes a non-empty line, other bytes append up to the per
// line limit) and drops the oldest completed line once the line limit is
// reached. A read transaction returns the character at a position counted
// from the oldest stored text, or zero beyond the stored length. Every
// transaction gives one result carrying the stored length and line count.
// A transaction first reads the character store and the line length queue,
// whose read data is registered, then edits and writes back once the output
// register can take its result; a new transaction is taken in the cycle after
// the write back, also while the previous result still waits in the output
// register. There is no clearing pass after reset: unwritten data is never used.
// Registers: line_limit at byte address 0, chars_per_line at byte address 4.
module terminal_line_history_buffer import tlhb_pkg::*; #(
    parameter int MAX_LINE_CHARS = DEF_MAX_LINE_CHARS,
    parameter int KEPT_LINES     = DEF_KEPT_LINES,
    parameter int STORE_DEPTH    = DEF_STORE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,

    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    t_cfg      r_cfg;
    logic      cfg_write;
    logic      out_free;
    logic      res_valid;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out;

    // write lands on the access cycle, pready is tied high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_limit     <= LINE_LIMIT_RST;
            r_cfg.chars_per_line <= CHARS_PER_LINE_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_LINE_LIMIT:     r_cfg.line_limit     <= pwdata[4:0];
                REG_CHARS_PER_LINE: r_cfg.chars_per_line <= pwdata[7:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // register readback, zero extended
    always_comb begin
        case (paddr[2])
            REG_LINE_LIMIT:     prdata = {27'd0, r_cfg.line_limit};
            REG_CHARS_PER_LINE: prdata = {24'd0, r_cfg.chars_per_line};
            default:            prdata = '0;
        endcase
    end

    // editing engine with both stores inside
    tlhb_engine #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS),
        .KEPT_LINES     (KEPT_LINES),
        .STORE_DEPTH    (STORE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register, refilled in the cycle its transaction completes
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/tlhb_ram.sv =====
module tlhb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tlhb_engine.sv =====
module tlhb_engine import tlhb_pkg::*; #(
    parameter int MAX_LINE_CHARS = DEF_MAX_LINE_CHARS,
    parameter int KEPT_LINES     = DEF_KEPT_LINES,
    parameter int STORE_DEPTH    = DEF_STORE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_free,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int LW       = $clog2(STORE_DEPTH + 1);
    localparam int SUMW     = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int LINE_CAP = (KEPT_LINES < QUEUE_DEPTH - 1) ? KEPT_LINES : QUEUE_DEPTH - 1;
    localparam logic [4:0]             LINE_CAP_V = 5'(LINE_CAP);
    localparam logic [LINE_CHAR_W-1:0] CHAR_CAP_V = LINE_CHAR_W'(MAX_LINE_CHARS);
    localparam logic [LW-1:0]          DEPTH_L    = LW'(STORE_DEPTH);
    localparam logic [SUMW-1:0]        DEPTH_S    = SUMW'(STORE_DEPTH);

    // text state
    logic [AW-1:0]          r_start,  n_start;
    logic [LW-1:0]          r_len,    n_len;
    logic [LINE_CNT_W-1:0]  r_cl,     n_cl;
    logic [LINE_CHAR_W-1:0] r_cur,    n_cur;
    logic                   r_col,    n_col;
    logic [QUEUE_AW-1:0]    r_head,   n_head;
    logic [QUEUE_AW-1:0]    r_tail,   n_tail;
    logic                   r_seen,   n_seen;

    // item in flight
    logic                   r_busy;
    t_in_item               r_item;
    logic                   r_idx_ok;

    logic                   accept;
    logic                   commit;
    logic [SUMW-1:0]        rd_sum;
    logic [AW-1:0]          rd_addr;
    logic [CHAR_W-1:0]      char_rdata;
    logic [LINE_CHAR_W-1:0] q_rdata;

    logic                   app;
    logic [CHAR_W-1:0]      app_data;
    logic                   push;
    logic                   ch;
    logic                   space;
    logic [4:0]             llim;
    logic [LINE_CHAR_W-1:0] climit;
    logic [LINE_CHAR_W-1:0] qval;
    logic [LW-1:0]          drop_n;
    logic                   seen_now;

    function automatic logic [AW-1:0] f_pos(input logic [AW-1:0] base,
                                            input logic [LW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + (AW+1)'(off);
        if (s >= (AW+1)'(STORE_DEPTH)) begin
            s = s - (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign commit     = r_busy && i_out_free;

    // read address for a read op, from the oldest stored character
    always_comb begin
        rd_sum = SUMW'(r_start) + SUMW'(i_in_data.read_index);
        if (rd_sum >= DEPTH_S) begin
            rd_sum = rd_sum - DEPTH_S;
        end
        rd_addr = rd_sum[AW-1:0];
    end

    tlhb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (commit && app),
        .i_waddr (f_pos(r_start, r_len)),
        .i_wdata (app_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (char_rdata)
    );

    tlhb_ram #(
        .WIDTH (LINE_CHAR_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QUEUE_AW)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (commit && push),
        .i_waddr (r_tail),
        .i_wdata (r_cur),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // effective limits
    always_comb begin
        llim = i_cfg.line_limit;
        if (llim == 5'd0) begin
            llim = 5'd1;
        end
        if (llim > LINE_CAP_V) begin
            llim = LINE_CAP_V;
        end
        climit = (i_cfg.chars_per_line > CHAR_CAP_V) ? CHAR_CAP_V : i_cfg.chars_per_line;
    end

    // line editing of the item in flight
    always_comb begin
        n_start  = r_start;
        n_len    = r_len;
        n_cl     = r_cl;
        n_cur    = r_cur;
        n_col    = r_col;
        n_head   = r_head;
        n_tail   = r_tail;
        n_seen   = r_seen;
        app      = 1'b0;
        app_data = r_item.data_byte;
        push     = 1'b0;
        ch       = 1'b0;
        space    = r_len < DEPTH_L;
        qval     = q_rdata;
        drop_n   = '0;
        seen_now = 1'b0;

        if (r_item.op == OP_PUT) begin
            if (r_item.data_byte == CH_ESC) begin
                n_col = 1'b1;
            end else if (r_item.data_byte == CH_M && r_col) begin
                n_col = 1'b0;
            end else if (r_item.data_byte == CH_CR) begin
                n_len = r_len - LW'(r_cur);
                n_cur = '0;
                ch    = 1'b1;
            end else if (r_item.data_byte == CH_LF) begin
                if (r_cur != '0 && space) begin
                    app      = 1'b1;
                    app_data = CH_LF;
                    push     = 1'b1;
                    n_len    = r_len + LW'(1);
                    n_tail   = r_tail + QUEUE_AW'(1);
                    n_cl     = r_cl + LINE_CNT_W'(1);
                    n_cur    = '0;
                    ch       = 1'b1;
                end
            end else if (r_item.data_byte == CH_BS) begin
                if (r_cur != '0) begin
                    n_cur = r_cur - LINE_CHAR_W'(1);
                    n_len = r_len - LW'(1);
                end
                ch = 1'b1;
            end else if (!r_col && r_cur < climit && space) begin
                app   = 1'b1;
                n_len = r_len + LW'(1);
                n_cur = r_cur + LINE_CHAR_W'(1);
                ch    = 1'b1;
            end

            // oldest line drop; an empty queue means the head is the entry
            // pushed right now, which the memory does not hold yet
            if (n_cl != '0 && n_cl >= llim) begin
                if (push && r_head == r_tail) begin
                    qval = r_cur;
                end
                drop_n = LW'(qval) + LW'(1);
                if (drop_n > n_len) begin
                    drop_n = n_len;
                end
                n_head  = r_head + QUEUE_AW'(1);
                n_start = f_pos(r_start, drop_n);
                n_len   = n_len - drop_n;
                n_cl    = n_cl - LINE_CNT_W'(1);
                ch      = 1'b1;
            end

            seen_now = r_seen | ch;
            n_seen   = r_item.last_of_call ? 1'b0 : seen_now;
        end
    end

    always_comb begin
        o_res_valid        = commit;
        o_res.byte_changed = ch;
        o_res.call_changed = (r_item.op == OP_PUT) && r_item.last_of_call && seen_now;
        o_res.read_char    = (r_item.op == OP_READ && r_idx_ok) ? char_rdata : '0;
        o_res.text_length  = TEXT_LEN_W'(n_len);
        o_res.line_count   = n_cl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_start <= '0;
            r_len   <= '0;
            r_cl    <= '0;
            r_cur   <= '0;
            r_col   <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_seen  <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy  <= 1'b0;
                r_start <= n_start;
                r_len   <= n_len;
                r_cl    <= n_cl;
                r_cur   <= n_cur;
                r_col   <= n_col;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_data;
            r_idx_ok <= SUMW'(i_in_data.read_index) < SUMW'(r_len);
        end
    end

endmodule

// ===== bench/tb.sv =====
import tlhb_pkg::*;

class history_scoreboard;

    // register copies
    bit [4:0] line_limit;
    bit [7:0] char_limit;

    // text history state
    bit [7:0] text_store [DEF_STORE_DEPTH];
    bit [7:0] line_lengths [QUEUE_DEPTH];
    int       start_ptr;
    int       text_len;
    int       lines;
    int       line_chars;
    int       head;
    int       tail;
    bit       in_colour;
    bit       call_seen;

    t_out_item results_due[$];

    // bookkeeping
    int mismatches;
    int results_checked;
    int puts;
    int reads;
    int reads_in_text;
    int drops;
    int refused;

    function new();
        line_limit = LINE_LIMIT_RST;
        char_limit = CHARS_PER_LINE_RST;
        start_ptr  = 0;
        text_len   = 0;
        lines      = 0;
        line_chars = 0;
        head       = 0;
        tail       = 0;
        in_colour  = 1'b0;
        call_seen  = 1'b0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
        if (idx == REG_LINE_LIMIT) begin
            line_limit = value[4:0];
        end else begin
            char_limit = value[7:0];
        end
    endfunction

    function int lines_kept();
        int l;
        l = int'(line_limit);
        if (l == 0) l = 1;
        if (l > DEF_KEPT_LINES) l = DEF_KEPT_LINES;
        if (l > QUEUE_DEPTH - 1) l = QUEUE_DEPTH - 1;
        return l;
    endfunction

    function int chars_allowed();
        return (int'(char_limit) > DEF_MAX_LINE_CHARS) ? DEF_MAX_LINE_CHARS : int'(char_limit);
    endfunction

    function bit add_char(bit [7:0] c);
        if (text_len >= DEF_STORE_DEPTH) return 1'b0;
        text_store[(start_ptr + text_len) % DEF_STORE_DEPTH] = c;
        text_len++;
        return 1'b1;
    endfunction

    // edits one received byte into the history, returns whether the text changed
    function bit edit_text(bit [7:0] b);
        bit changed;
        bit plain;
        int n;
        changed = 1'b0;
        plain   = 1'b0;
        if (b == CH_ESC) begin
            in_colour = 1'b1;
        end else if (b == CH_M && in_colour) begin
            in_colour = 1'b0;
        end else if (b == CH_CR) begin
            text_len  -= line_chars;
            line_chars = 0;
            changed    = 1'b1;
        end else if (b == CH_LF) begin
            if (line_chars > 0 && add_char(CH_LF)) begin
                line_lengths[tail] = 8'(line_chars);
                tail       = (tail + 1) % QUEUE_DEPTH;
                lines++;
                line_chars = 0;
                changed    = 1'b1;
            end
        end else if (b == CH_BS) begin
            if (line_chars > 0) begin
                line_chars--;
                text_len--;
            end
            changed = 1'b1;
        end else begin
            plain = 1'b1;
        end

        if (plain && !in_colour) begin
            if (line_chars < chars_allowed()) begin
                if (add_char(b)) begin
                    line_chars++;
                    changed = 1'b1;
                end
            end else begin
                refused++;
            end
        end

        // oldest line falls out once the line limit is reached
        if (lines > 0 && lines >= lines_kept()) begin
            n = int'(line_lengths[head]) + 1;
            if (n > text_len) n = text_len;
            head      = (head + 1) % QUEUE_DEPTH;
            start_ptr = (start_ptr + n) % DEF_STORE_DEPTH;
            text_len -= n;
            lines--;
            changed   = 1'b1;
            drops++;
        end
        return changed;
    endfunction

    function void note_transaction(t_in_item it);
        t_out_item r;
        bit ch;
        r = '0;
        if (it.op == OP_PUT) begin
            ch = edit_text(it.data_byte);
            r.byte_changed = ch;
            if (ch) call_seen = 1'b1;
            if (it.last_of_call) begin
                r.call_changed = call_seen;
                call_seen      = 1'b0;
            end
            puts++;
        end else begin
            if (int'(it.read_index) < text_len) begin
                r.read_char = text_store[(start_ptr + int'(it.read_index)) % DEF_STORE_DEPTH];
                reads_in_text++;
            end
            reads++;
        end
        r.text_length = TEXT_LEN_W'(text_len);
        r.line_count  = LINE_CNT_W'(lines);
        results_due.push_back(r);
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at result %0d: %s", results_checked, msg);
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void check_transaction(t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            flag("result arrived with no transaction outstanding");
            return;
        end
        want = results_due.pop_front();
        compare_field("byte_changed", int'(want.byte_changed), int'(got.byte_changed));
        compare_field("call_changed", int'(want.call_changed), int'(got.call_changed));
        compare_field("read_char", int'(want.read_char), int'(got.read_char));
        compare_field("text_length", int'(want.text_length), int'(got.text_length));
        compare_field("line_count", int'(want.line_count), int'(got.line_count));
        results_checked++;
    endfunction

endclass

module tb;

    localparam int CYCLE_LIMIT = 400000;

    // clock and synchronous active-low reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port, idle from time zero
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // input and result channels
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    history_scoreboard sb = new();

    int sent_items  = 0;
    int cycle_count = 0;
    int settings    = 0;
    bit calm        = 1'b0;   // no idling on either side while set

    always #2 i_clk = ~i_clk;

    terminal_line_history_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // result side stalls in about a third of the cycles unless calm
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // watch both channels: every accepted input transaction gets a prediction,
    // every accepted result is checked against the oldest one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_transaction(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_transaction(o_out_data);
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one input transaction; valid stays up from one item to the next
    // unless an idle gap is inserted
    task automatic push_item(t_in_item it);
        if (!calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic put_byte(logic [7:0] b, bit last);
        t_in_item it;
        it.op           = OP_PUT;
        it.data_byte    = b;
        it.read_index   = INDEX_W'($urandom_range(0, 4095));   // ignored on a put
        it.last_of_call = last;
        push_item(it);
    endtask

    // put with a random end of call
    task automatic put_in_call(logic [7:0] b);
        put_byte(b, $urandom_range(0, 3) == 0);
    endtask

    task automatic read_char_at(int idx);
        t_in_item it;
        it.op           = OP_READ;
        it.data_byte    = CHAR_W'($urandom_range(0, 255));    // ignored on a read
        it.read_index   = INDEX_W'(idx);
        it.last_of_call = 1'($urandom_range(0, 1));
        push_item(it);
    endtask

    // mostly inside the stored text, sometimes anywhere in the index range
    task automatic random_read();
        if ($urandom_range(0, 9) < 7) begin
            read_char_at($urandom_range(0, sb.text_len));
        end else begin
            read_char_at($urandom_range(0, 4095));
        end
    endtask

    // ESC [ digits ; digits m, the closing 'm' left out now and then
    task automatic colour_sequence();
        put_in_call(CH_ESC);
        put_in_call(8'h5B);
        repeat ($urandom_range(1, 2)) put_in_call(8'($urandom_range(8'h30, 8'h39)));
        if ($urandom_range(0, 1)) begin
            put_in_call(8'h3B);
            put_in_call(8'($urandom_range(8'h30, 8'h39)));
        end
        if ($urandom_range(0, 6) != 0) put_in_call(CH_M);
    endtask

    // one line of terminal text with edits, colour and reads mixed in
    task automatic terminal_line(int max_len);
        int n;
        int r;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 140)
                                         : $urandom_range(0, max_len);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) colour_sequence();
            else if (r < 13) put_in_call(CH_BS);
            else if (r < 16) put_in_call(8'($urandom_range(0, 255)));
            else if (r < 26) random_read();
            else put_in_call(8'($urandom_range(8'h20, 8'h7E)));
        end
        r = $urandom_range(0, 99);
        if (r < 78) begin
            put_in_call(CH_LF);
        end else if (r < 86) begin
            put_in_call(CH_CR);
        end else if (r < 94) begin
            // blank line right after, must be suppressed
            put_in_call(CH_LF);
            put_in_call(CH_LF);
        end
        // otherwise the line stays open into the next one
    endtask

    // setup then access cycle; upper data bits are junk the register must drop
    task automatic write_register(logic idx, logic [7:0] value);
        logic [31:0] word;
        word    = {$urandom_range(0, 32'hFFFF_FFFF)} & ~32'hFF;
        word    = word | {24'd0, (idx == REG_LINE_LIMIT) ? (value & 8'h1F) : value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, word);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic text_phase(logic [4:0] lines_limit, logic [7:0] chars_limit,
                              int item_count, int max_len, bit quiet);
        int stop_at;
        drain();
        write_register(REG_LINE_LIMIT, {3'd0, lines_limit});
        write_register(REG_CHARS_PER_LINE, chars_limit);
        settings++;
        calm    = quiet;
        stop_at = sent_items + item_count;
        while (sent_items < stop_at) terminal_line(max_len);
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset register values
        read_char_at(0);                 // empty history reads zero
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);           // call ends with a change
        put_byte(CH_ESC, 1'b1);          // call with no change
        put_byte("x", 1'b0);             // dropped inside colour
        put_byte(CH_ESC, 1'b0);          // second ESC keeps it open
        put_byte(CH_M, 1'b0);            // closes the sequence
        put_byte(CH_M, 1'b0);            // stray m is plain text
        put_byte(CH_BS, 1'b0);
        put_byte(CH_LF, 1'b0);
        put_byte(CH_LF, 1'b1);           // blank line suppressed
        put_byte(CH_CR, 1'b0);           // CR on empty line still counts
        put_byte(CH_BS, 1'b1);           // BS on empty line still counts
        put_byte("q", 1'b0);
        put_byte(CH_CR, 1'b0);
        put_byte("z", 1'b0);
        put_byte(CH_ESC, 1'b0);
        put_byte(CH_LF, 1'b0);           // LF acts inside colour
        put_byte(CH_CR, 1'b0);           // CR acts inside colour
        put_byte(CH_M, 1'b1);
        read_char_at(0);
        read_char_at(1);
        read_char_at(4095);
        read_char_at(2);

        // random part over several register settings, extremes included;
        // the second phase lowers both limits under what is already stored
        text_phase(5'd31, 8'd128, 450, 40, 1'b0);
        text_phase(5'd3,  8'd20,  300, 30, 1'b0);
        text_phase(5'd1,  8'd1,   200, 6,  1'b0);
        text_phase(5'd0,  8'd0,   120, 8,  1'b0);
        text_phase(5'd17, 8'd255, 400, 60, 1'b1);   // long stretch without idling
        text_phase(5'd31, 8'd200, 400, 80, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.results_due.size() != 0) sb.flag("results still outstanding at the end");

        $display("covered %0d puts and %0d reads (%0d inside the text) over %0d settings",
                 sb.puts, sb.reads, sb.reads_in_text, settings);
        $display("%0d oldest-line drops, %0d characters refused at the line limit, %0d mismatches",
                 sb.drops, sb.refused, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
